FILE: hdl/sorted_deadline_timer_queue_top_macros.svh
// Assertion helpers used by the timer queue sequencer.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_TOP_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SDTQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define SDTQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SDTQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define SDTQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: hdl/sdtq_pkg.sv
`default_nettype none
package sdtq_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int ID_WIDTH   = 16;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [1:0] KIND_SET     = 2'd0;
    localparam logic [1:0] KIND_STOP    = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_WAIT    = 2'd3;

    typedef struct packed {
        logic [1:0]            op;
        logic [ID_WIDTH-1:0]   timer_id;
        logic [TIME_WIDTH-1:0] deadline;
        logic [TIME_WIDTH-1:0] now;
    } sdtq_in_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [ID_WIDTH-1:0]   out_id;
        logic                  ok;
        logic [TIME_WIDTH-1:0] wait_res;
        logic                  last;
    } sdtq_out_t;

    typedef struct packed {
        logic [ID_WIDTH-1:0]   id;
        logic [TIME_WIDTH-1:0] deadline;
    } sdtq_entry_t;

    typedef struct packed {
        logic                  le;
        logic                  id_eq;
        logic [TIME_WIDTH-1:0] diff;
    } sdtq_cmp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SET_RD,
        S_SET_CMP,
        S_STOP_RD,
        S_STOP_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_CHK_RD,
        S_CHK_CMP,
        S_EMIT
    } sdtq_state_t;

endpackage
`default_nettype wire

FILE: hdl/sdtq_alu.sv
`default_nettype none
module sdtq_alu
    import sdtq_pkg::*;
(
    input  wire logic [TIME_WIDTH-1:0] a_time,
    input  wire logic [TIME_WIDTH-1:0] b_time,
    input  wire logic [ID_WIDTH-1:0]   a_id,
    input  wire logic [ID_WIDTH-1:0]   b_id,
    output sdtq_cmp_t                  cmp
);

    logic [TIME_WIDTH:0] sub;

    // a - b with borrow; a <= b when it borrows or lands on zero
    assign sub       = {1'b0, a_time} - {1'b0, b_time};
    assign cmp.le    = sub[TIME_WIDTH] | (sub[TIME_WIDTH-1:0] == '0);
    assign cmp.diff  = sub[TIME_WIDTH-1:0];
    assign cmp.id_eq = (a_id == b_id);

endmodule
`default_nettype wire

FILE: hdl/sdtq_store.sv
`default_nettype none
module sdtq_store
    import sdtq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire sdtq_entry_t   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output sdtq_entry_t        rd_data
);

    sdtq_entry_t store_reg [DEPTH];
    sdtq_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: hdl/sdtq_seq.sv
`default_nettype none
`include "sorted_deadline_timer_queue_top_macros.svh"
module sdtq_seq
    import sdtq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire sdtq_in_t      s_data,
    output logic               emit_valid,
    input  wire logic          emit_ready,
    output sdtq_out_t          emit_data,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output sdtq_entry_t        wr_data,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    input  wire sdtq_entry_t   rd_data
);

    localparam int CW = $clog2(DEPTH + 1);

    sdtq_state_t           state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         idx_reg, idx_next;
    sdtq_out_t             res_reg, res_next;
    logic [1:0]            op_reg;
    logic [ID_WIDTH-1:0]   id_reg;
    logic [TIME_WIDTH-1:0] dl_reg;
    logic [TIME_WIDTH-1:0] now_reg;

    logic [TIME_WIDTH-1:0] cmp_b;
    sdtq_cmp_t             cmp;
    logic [CW-1:0]         idx_inc;
    logic [CW-1:0]         idx_dec;
    logic                  full;
    logic                  shift_end;
    sdtq_entry_t           new_entry;

    assign cmp_b     = (op_reg == OP_SET) ? dl_reg : now_reg;
    assign idx_inc   = idx_reg + CW'(1);
    assign idx_dec   = idx_reg - CW'(1);
    assign full      = (cnt_reg == CW'(DEPTH));
    assign shift_end = (idx_inc >= cnt_reg);
    assign new_entry = '{id: id_reg, deadline: dl_reg};

    sdtq_alu u_alu (
        .a_time (rd_data.deadline),
        .b_time (cmp_b),
        .a_id   (rd_data.id),
        .b_id   (id_reg),
        .cmp    (cmp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        res_reg <= res_next;
        if (s_valid && s_ready) begin
            op_reg  <= s_data.op;
            id_reg  <= s_data.timer_id;
            dl_reg  <= s_data.deadline;
            now_reg <= s_data.now;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (op_reg)
                    OP_SET:   state_next = full ? S_EMIT : S_SET_RD;
                    OP_STOP:  state_next = (id_reg == '0) ? S_EMIT : S_STOP_RD;
                    OP_CHECK: state_next = S_CHK_RD;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_SET_RD: begin
                state_next = (idx_reg == '0) ? S_EMIT : S_SET_CMP;
            end
            S_SET_CMP: begin
                state_next = cmp.le ? S_EMIT : S_SET_RD;
            end
            S_STOP_RD: begin
                state_next = (idx_reg == cnt_reg) ? S_EMIT : S_STOP_CMP;
            end
            S_STOP_CMP: begin
                state_next = cmp.id_eq ? S_SHIFT_RD : S_STOP_RD;
            end
            S_SHIFT_RD: begin
                if (!shift_end) state_next = S_SHIFT_WR;
                else if (op_reg == OP_CHECK) state_next = S_CHK_RD;
                else state_next = S_EMIT;
            end
            S_SHIFT_WR: begin
                state_next = S_SHIFT_RD;
            end
            S_CHK_RD: begin
                state_next = (cnt_reg == '0) ? S_EMIT : S_CHK_CMP;
            end
            S_CHK_CMP: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                // an expired beat is followed by removal of the head entry
                if (emit_ready) state_next = res_reg.last ? S_IDLE : S_SHIFT_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        emit_valid = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = idx_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = rd_data;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_DISPATCH: begin
                res_next = '{kind: KIND_SET, out_id: id_reg, ok: 1'b0,
                             wait_res: '0, last: 1'b1};
                idx_next = '0;
                if (op_reg == OP_SET) begin
                    idx_next = cnt_reg;
                end else if (op_reg == OP_STOP) begin
                    res_next.kind = KIND_STOP;
                end
            end
            S_SET_RD: begin
                if (idx_reg == '0) begin
                    wr_en       = 1'b1;
                    wr_data     = new_entry;
                    cnt_next    = cnt_reg + CW'(1);
                    res_next.ok = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_dec[AW-1:0];
                end
            end
            S_SET_CMP: begin
                // walk from the tail: move later entries up one slot
                wr_en = 1'b1;
                if (cmp.le) begin
                    wr_data     = new_entry;
                    cnt_next    = cnt_reg + CW'(1);
                    res_next.ok = 1'b1;
                end else begin
                    idx_next = idx_dec;
                end
            end
            S_STOP_RD: begin
                rd_en = (idx_reg != cnt_reg);
            end
            S_STOP_CMP: begin
                if (cmp.id_eq) res_next.ok = 1'b1;
                else idx_next = idx_inc;
            end
            S_SHIFT_RD: begin
                if (shift_end) begin
                    cnt_next = cnt_reg - CW'(1);
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_inc[AW-1:0];
                end
            end
            S_SHIFT_WR: begin
                wr_en    = 1'b1;
                idx_next = idx_inc;
            end
            S_CHK_RD: begin
                if (cnt_reg == '0) begin
                    res_next = '{kind: KIND_WAIT, out_id: '0, ok: 1'b1,
                                 wait_res: '0, last: 1'b1};
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end
            end
            S_CHK_CMP: begin
                if (cmp.le) begin
                    res_next = '{kind: KIND_EXPIRED, out_id: rd_data.id, ok: 1'b1,
                                 wait_res: '0, last: 1'b0};
                end else begin
                    res_next = '{kind: KIND_WAIT, out_id: '0, ok: 1'b1,
                                 wait_res: cmp.diff, last: 1'b1};
                end
            end
            S_EMIT: begin
                emit_valid = 1'b1;
                if (emit_ready && !res_reg.last) idx_next = '0;
            end
            default: begin
            end
        endcase
    end

    assign emit_data = res_reg;

    `SDTQ_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CW'(DEPTH),
        "entry count above depth")
    `SDTQ_ASSERT_IMP(a_mem_quiet, aclk, aresetn,
        (state_reg == S_IDLE) || (state_reg == S_EMIT) || (state_reg == S_DISPATCH),
        !wr_en && !rd_en, "store accessed outside a walk")
    `SDTQ_ASSERT_IMP(a_last_kind, aclk, aresetn, emit_valid,
        res_reg.last == (res_reg.kind != KIND_EXPIRED), "last flag does not match result kind")
    `SDTQ_ASSERT_NXT(a_back_idle, aclk, aresetn, emit_valid && emit_ready && res_reg.last,
        s_ready, "not ready after final beat")

endmodule
`default_nettype wire

FILE: hdl/sorted_deadline_timer_queue_top.sv
`default_nettype none
// Sorted timer queue: holds up to DEPTH (id, deadline) timers in one memory with a
// registered read port, kept in ascending deadline order with ties in arrival order. One
// request is worked at a time; s_ready is high only in the idle state between requests.
// Every entry visited takes a registered memory read, then a compare in the shared
// subtract/compare unit or a write-back. A set walks up from the tail, moving later
// entries up one slot until its place is found; a full queue rejects it with ok low. A
// stop searches from the head and moves the entries behind the hit down one slot; id zero
// or a miss ends with ok low. A check emits one expired beat per timer at or past now,
// each followed by removal of the head entry, then a final wait beat (zero when the list
// is empty); an unused op returns to idle with no result. A stall on m_ready holds the
// emit state. Results leave through an output register, so the next request can be taken
// while the last beat of the previous one waits on m_ready.
module sorted_deadline_timer_queue_top
    import sdtq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire sdtq_in_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output sdtq_out_t     m_data
);

    localparam int AW = $clog2(DEPTH);

    logic          emit_valid;
    logic          emit_ready;
    sdtq_out_t     emit_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    sdtq_entry_t   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    sdtq_entry_t   rd_data;
    logic          m_valid_reg;
    sdtq_out_t     m_data_reg;

    sdtq_seq #(.DEPTH(DEPTH), .AW(AW)) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit_data  (emit_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    sdtq_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // take a new beat when the output slot is empty or drains this cycle
    assign emit_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_ready) begin
            m_valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_valid && emit_ready) begin
            m_data_reg <= emit_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire
